### rtl/mewt_pkg.sv
`default_nettype none
package mewt_pkg;

    // default table geometry
    localparam int TABLE_ENTRIES_DEF = 4096;
    localparam int PROBE_LIMIT_DEF   = 4096;

    // hash mixing constants
    localparam logic [63:0] MIX_GOLDEN = 64'h9E3779B97F4A7C15;
    localparam logic [63:0] MIX_C1     = 64'hFF51AFD7ED558CCD;
    localparam logic [63:0] MIX_C2     = 64'hC4CEB9FE1A85EC53;

    localparam logic [16:0] WEIGHT_MAX = 17'd65536;

    // request commands
    localparam logic CMD_HASH = 1'b0;
    localparam logic CMD_READ = 1'b1;

    // result kinds
    localparam logic KIND_EDGE = 1'b0;
    localparam logic KIND_SLOT = 1'b1;

    // one table slot as stored in memory
    typedef struct packed {
        logic        valid;
        logic [63:0] smaller;
        logic [63:0] larger;
        logic [16:0] weight;
        logic [15:0] last_asm;
    } mewt_entry_t;

    // one result item
    typedef struct packed {
        logic        result_kind;
        logic        edge_present;
        logic [63:0] smaller_hash;
        logic [63:0] larger_hash;
        logic [16:0] edge_weight;
        logic        newly_inserted;
        logic        table_overflow;
    } mewt_rsp_t;

endpackage
`default_nettype wire

### rtl/mewt_if.sv
`default_nettype none
interface mewt_req_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [63:0] minimizer_hash;
    logic [15:0] assembly_number;
    logic        record_start;
    logic [11:0] slot_index;

    modport source (output valid, command, minimizer_hash, assembly_number, record_start,
                    slot_index, input ready);
    modport sink (input valid, command, minimizer_hash, assembly_number, record_start,
                  slot_index, output ready);
endinterface

interface mewt_rsp_if;
    logic        valid;
    logic        ready;
    logic        result_kind;
    logic        edge_present;
    logic [63:0] smaller_hash;
    logic [63:0] larger_hash;
    logic [16:0] edge_weight;
    logic        newly_inserted;
    logic        table_overflow;

    modport source (output valid, result_kind, edge_present, smaller_hash, larger_hash,
                    edge_weight, newly_inserted, table_overflow, input ready);
    modport sink (input valid, result_kind, edge_present, smaller_hash, larger_hash,
                  edge_weight, newly_inserted, table_overflow, output ready);
endinterface
`default_nettype wire

### rtl/mewt_ram.sv
`default_nettype none
module mewt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

### rtl/mewt_hash.sv
`default_nettype none
module mewt_hash import mewt_pkg::*; #(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             start,
    input  wire logic [63:0]                      lo,
    input  wire logic [63:0]                      hi,
    output logic                                  done,
    output logic      [$clog2(TABLE_ENTRIES)-1:0] slot
);

    localparam int  IDX_W = $clog2(TABLE_ENTRIES);
    localparam bit  POW2  = (TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0;
    // 2^32 mod N folds the upper word, floor(2^64 / N) estimates the quotient
    localparam logic [31:0] FOLD_R = 32'(64'h1_0000_0000 % 64'(TABLE_ENTRIES));
    localparam logic [63:0] RECIP  = 64'hFFFF_FFFF_FFFF_FFFF / 64'(TABLE_ENTRIES);
    localparam logic [31:0] MOD_N  = 32'(TABLE_ENTRIES);

    typedef enum logic [3:0] {
        H_IDLE = 4'b0001,
        H_MIX  = 4'b0010,
        H_MOD  = 4'b0100,
        H_DONE = 4'b1000
    } hstate_t;

    hstate_t          state_reg, state_next;
    logic [63:0]      x_reg, x_next;
    logic [63:0]      acc_reg, acc_next;
    logic [63:0]      lo_reg, lo_next;
    logic [3:0]       step_reg, step_next;
    logic             round_reg, round_next;
    logic [IDX_W-1:0] rem_reg, rem_next;

    logic [63:0] coef;
    logic [31:0] mul_a, mul_b;
    logic [63:0] prod;
    logic [63:0] xs;

    // shared 32x32 multiplier, three partial products per 64-bit multiply
    assign coef  = (step_reg < 4'd4) ? MIX_C1 : MIX_C2;
    assign prod  = mul_a * mul_b;
    assign xs    = x_reg ^ (x_reg >> 33);

    // multiplier operands for mixing and for the remainder
    always_comb
    begin
        if (state_reg == H_MOD)
        begin
            case (step_reg)
                4'd0, 4'd1, 4'd2, 4'd3:
                begin
                    mul_a = x_reg[63:32];
                    mul_b = FOLD_R;
                end
                4'd4:
                begin
                    mul_a = x_reg[31:0];
                    mul_b = RECIP[31:0];
                end
                4'd5:
                begin
                    mul_a = x_reg[31:0];
                    mul_b = RECIP[63:32];
                end
                default:
                begin
                    mul_a = acc_reg[63:32];
                    mul_b = MOD_N;
                end
            endcase
        end
        else
        begin
            mul_a = (step_reg == 4'd3 || step_reg == 4'd7) ? x_reg[63:32] : x_reg[31:0];
            mul_b = (step_reg == 4'd2 || step_reg == 4'd6) ? coef[63:32] : coef[31:0];
        end
    end

    assign done = (state_reg == H_DONE);
    assign slot = POW2 ? x_reg[IDX_W-1:0] : rem_reg;

    always_comb
    begin
        state_next = state_reg;
        x_next     = x_reg;
        acc_next   = acc_reg;
        lo_next    = lo_reg;
        step_next  = step_reg;
        round_next = round_reg;
        rem_next   = rem_reg;
        case (state_reg)
            H_IDLE:
            begin
                if (start)
                begin
                    x_next     = hi + MIX_GOLDEN;
                    lo_next    = lo;
                    step_next  = '0;
                    round_next = 1'b0;
                    state_next = H_MIX;
                end
            end
            H_MIX:
            begin
                step_next = step_reg + 4'd1;
                case (step_reg)
                    4'd0, 4'd4: x_next = xs;
                    4'd1, 4'd5: acc_next = prod;
                    4'd2, 4'd6: acc_next = acc_reg + {prod[31:0], 32'd0};
                    4'd3, 4'd7: x_next = acc_reg + {prod[31:0], 32'd0};
                    default:
                    begin
                        step_next = '0;
                        if (!round_reg)
                        begin
                            x_next     = lo_reg ^ xs;
                            round_next = 1'b1;
                        end
                        else
                        begin
                            x_next     = xs;
                            rem_next   = '0;
                            state_next = POW2 ? H_DONE : H_MOD;
                        end
                    end
                endcase
            end
            H_MOD:
            begin
                // four folds bring the value below 2^32, then quotient estimate
                // by reciprocal, back-multiply and one correcting subtract
                step_next = step_reg + 4'd1;
                case (step_reg)
                    4'd0, 4'd1, 4'd2, 4'd3: x_next = prod + {32'd0, x_reg[31:0]};
                    4'd4: acc_next = prod;
                    4'd5: acc_next = prod + {32'd0, acc_reg[63:32]};
                    4'd6: x_next = {32'd0, x_reg[31:0] - prod[31:0]};
                    default:
                    begin
                        rem_next   = (x_reg[31:0] >= MOD_N) ? IDX_W'(x_reg[31:0] - MOD_N)
                                                            : IDX_W'(x_reg[31:0]);
                        state_next = H_DONE;
                    end
                endcase
            end
            H_DONE:
            begin
                state_next = H_IDLE;
            end
            default:
            begin
                state_next = H_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= H_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        x_reg     <= x_next;
        acc_reg   <= acc_next;
        lo_reg    <= lo_next;
        step_reg  <= step_next;
        round_reg <= round_next;
        rem_reg   <= rem_next;
    end

endmodule
`default_nettype wire

### rtl/minimizer_edge_weight_table.sv
`default_nettype none
// Edge weight table for adjacent minimizer pairs. Each hash request pairs the hash with
// the previous one of its record, orders the pair and finds it in a linear-probing hash
// table held in one single-port-write memory; a new edge gets weight 1, a known edge
// gains one only under a new assembly number, saturating at 65536. A read request
// returns one slot. After reset the block sweeps the memory to clear every slot and
// takes no request meanwhile. An edge is hashed in the hash unit (one shared 32x32
// multiplier, three partial products per 64-bit multiply), with a remainder by folding
// and reciprocal multiplication when TABLE_ENTRIES is not a power of two, and then
// probed slot by slot. A finished result waits in an output register while the next
// request is taken.
module minimizer_edge_weight_table import mewt_pkg::*; #(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
    parameter int PROBE_LIMIT   = PROBE_LIMIT_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    mewt_req_if.sink  req,
    mewt_rsp_if.source rsp
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int LIMIT = (PROBE_LIMIT < TABLE_ENTRIES) ? PROBE_LIMIT : TABLE_ENTRIES;
    localparam int CNT_W = $clog2(LIMIT + 1);
    localparam int ENT_W = $bits(mewt_entry_t);
    localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(TABLE_ENTRIES - 1);

    typedef enum logic [5:0] {
        ST_CLEAR = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_RDOUT = 6'b000100,
        ST_HASH  = 6'b001000,
        ST_PROBE = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] clr_reg, clr_next;
    logic             have_prev_reg, have_prev_next;
    logic             overflow_reg, overflow_next;
    logic             out_valid_reg, out_valid_next;
    mewt_rsp_t        out_reg, out_next;
    mewt_rsp_t        res_reg, res_next;
    logic [63:0]      prev_reg, prev_next;
    logic [63:0]      lo_reg, lo_next;
    logic [63:0]      hi_reg, hi_next;
    logic [15:0]      asm_reg, asm_next;
    logic [IDX_W-1:0] pos_reg, pos_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    logic             accept;
    logic [63:0]      edge_lo, edge_hi;
    logic             hash_start, hash_done;
    logic [IDX_W-1:0] hash_slot;
    logic [IDX_W-1:0] pos_inc;
    logic [CNT_W-1:0] cnt_inc;
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr, ram_raddr;
    mewt_entry_t      ram_wentry;
    logic [ENT_W-1:0] ram_rdata;
    mewt_entry_t      q;
    logic [16:0]      w_new;

    assign accept  = req.valid && req.ready;
    assign edge_lo = (prev_reg < req.minimizer_hash) ? prev_reg : req.minimizer_hash;
    assign edge_hi = (prev_reg < req.minimizer_hash) ? req.minimizer_hash : prev_reg;
    assign hash_start = accept && req.command == CMD_HASH && !req.record_start
                        && have_prev_reg;
    assign pos_inc = (pos_reg == LAST_SLOT) ? '0 : pos_reg + 1'b1;
    assign cnt_inc = cnt_reg + 1'b1;
    assign q       = mewt_entry_t'(ram_rdata);
    assign w_new   = (q.weight < WEIGHT_MAX) ? q.weight + 17'd1 : q.weight;

    mewt_hash #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_hash (
        .clk  (clk),
        .rst_n(rst_n),
        .start(hash_start),
        .lo   (edge_lo),
        .hi   (edge_hi),
        .done (hash_done),
        .slot (hash_slot)
    );

    mewt_ram #(
        .WIDTH(ENT_W),
        .DEPTH(TABLE_ENTRIES)
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wentry),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // read address follows the step that consumes the data next cycle
    always_comb
    begin
        case (state_reg)
            ST_IDLE:  ram_raddr = IDX_W'(req.slot_index);
            ST_HASH:  ram_raddr = hash_slot;
            ST_PROBE: ram_raddr = pos_inc;
            default:  ram_raddr = pos_reg;
        endcase
    end

    // main sequencer
    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        have_prev_next = have_prev_reg;
        overflow_next  = overflow_reg;
        res_next       = res_reg;
        prev_next      = prev_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        asm_next       = asm_reg;
        pos_next       = pos_reg;
        cnt_next       = cnt_reg;
        ram_we         = 1'b0;
        ram_waddr      = pos_reg;
        ram_wentry     = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == LAST_SLOT)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    res_next = '0;
                    if (req.command == CMD_READ)
                    begin
                        res_next.result_kind = KIND_SLOT;
                        state_next = (32'(req.slot_index) < TABLE_ENTRIES) ? ST_RDOUT
                                                                          : ST_DONE;
                    end
                    else
                    begin
                        res_next.result_kind = KIND_EDGE;
                        prev_next      = req.minimizer_hash;
                        have_prev_next = 1'b1;
                        lo_next        = edge_lo;
                        hi_next        = edge_hi;
                        asm_next       = req.assembly_number;
                        state_next     = hash_start ? ST_HASH : ST_DONE;
                    end
                end
            end
            ST_RDOUT:
            begin
                if (q.valid)
                begin
                    res_next.edge_present = 1'b1;
                    res_next.smaller_hash = q.smaller;
                    res_next.larger_hash  = q.larger;
                    res_next.edge_weight  = q.weight;
                end
                state_next = ST_DONE;
            end
            ST_HASH:
            begin
                if (hash_done)
                begin
                    pos_next   = hash_slot;
                    cnt_next   = '0;
                    state_next = ST_PROBE;
                end
            end
            ST_PROBE:
            begin
                res_next.edge_present = 1'b1;
                res_next.smaller_hash = lo_reg;
                res_next.larger_hash  = hi_reg;
                ram_wentry.valid      = 1'b1;
                ram_wentry.smaller    = lo_reg;
                ram_wentry.larger     = hi_reg;
                ram_wentry.last_asm   = asm_reg;
                if (!q.valid)
                begin
                    // free slot: insert
                    ram_we                  = 1'b1;
                    ram_wentry.weight       = 17'd1;
                    res_next.edge_weight    = 17'd1;
                    res_next.newly_inserted = 1'b1;
                    state_next              = ST_DONE;
                end
                else if (q.smaller == lo_reg && q.larger == hi_reg)
                begin
                    // known edge: count a new assembly once
                    ram_wentry.weight    = w_new;
                    res_next.edge_weight = q.weight;
                    if (q.last_asm != asm_reg)
                    begin
                        ram_we               = 1'b1;
                        res_next.edge_weight = w_new;
                    end
                    state_next = ST_DONE;
                end
                else if (cnt_inc == CNT_W'(LIMIT))
                begin
                    // probe limit reached: drop the edge
                    overflow_next = 1'b1;
                    state_next    = ST_DONE;
                end
                else
                begin
                    pos_next = pos_inc;
                    cnt_next = cnt_inc;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output register
    always_comb
    begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (state_reg == ST_DONE && (!out_valid_reg || rsp.ready))
        begin
            out_next                = res_reg;
            out_next.table_overflow = overflow_reg;
            out_valid_next          = 1'b1;
        end
    end

    assign req.ready          = (state_reg == ST_IDLE);
    assign rsp.valid          = out_valid_reg;
    assign rsp.result_kind    = out_reg.result_kind;
    assign rsp.edge_present   = out_reg.edge_present;
    assign rsp.smaller_hash   = out_reg.smaller_hash;
    assign rsp.larger_hash    = out_reg.larger_hash;
    assign rsp.edge_weight    = out_reg.edge_weight;
    assign rsp.newly_inserted = out_reg.newly_inserted;
    assign rsp.table_overflow = out_reg.table_overflow;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            have_prev_reg <= 1'b0;
            overflow_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            prev_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            have_prev_reg <= have_prev_next;
            overflow_reg  <= overflow_next;
            out_valid_reg <= out_valid_next;
            prev_reg      <= prev_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
        res_reg <= res_next;
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        asm_reg <= asm_next;
        pos_reg <= pos_next;
        cnt_reg <= cnt_next;
    end

`ifndef ASSERT_OFF
    a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !req.ready)
        else $error("request taken during clearing pass");

    a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == ST_CLEAR || state_reg == ST_PROBE))
        else $error("table written outside clear or probe");

    a_overflow_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        overflow_reg |=> overflow_reg)
        else $error("overflow flag cleared");

    a_probe_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PROBE) |-> (cnt_reg < CNT_W'(LIMIT)))
        else $error("probe count beyond limit");
`endif

endmodule
`default_nettype wire

### dv/tb_minimizer_edge_weight_table.sv
`default_nettype none
module tb_minimizer_edge_weight_table;
    import mewt_pkg::*;

    localparam int SLOTS       = TABLE_ENTRIES_DEF;
    localparam int PROBES      = PROBE_LIMIT_DEF;
    localparam int STALL_LIMIT = 20000;

    logic clk;
    logic rst_n;

    mewt_req_if req_if ();
    mewt_rsp_if rsp_if ();

    minimizer_edge_weight_table dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if.sink),
        .rsp   (rsp_if.source)
    );

    // clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // shadow copy of the edge table
    bit          shadow_valid [SLOTS];
    logic [63:0] shadow_lo [SLOTS];
    logic [63:0] shadow_hi [SLOTS];
    logic [16:0] shadow_weight [SLOTS];
    logic [15:0] shadow_asm [SLOTS];
    logic [63:0] last_hash;
    bit          last_hash_seen;
    bit          overflow_flag;
    int          used_slots [$];

    mewt_rsp_t   pending_results [$];
    int          mismatches;
    bit          quiet;
    int          hold_request;
    int          idle_cycles;

    function automatic logic [63:0] avalanche(logic [63:0] x);
        x = x ^ (x >> 33);
        x = x * MIX_C1;
        x = x ^ (x >> 33);
        x = x * MIX_C2;
        x = x ^ (x >> 33);
        return x;
    endfunction

    function automatic int edge_home(logic [63:0] lo, logic [63:0] hi);
        logic [63:0] h;
        h = avalanche(lo ^ avalanche(hi + MIX_GOLDEN));
        return int'(h % SLOTS);
    endfunction

    function automatic mewt_rsp_t make_result(logic kind, logic present, logic [63:0] lo,
                                              logic [63:0] hi, logic [16:0] weight,
                                              logic fresh);
        mewt_rsp_t r;
        r.result_kind    = kind;
        r.edge_present   = present;
        r.smaller_hash   = lo;
        r.larger_hash    = hi;
        r.edge_weight    = weight;
        r.newly_inserted = fresh;
        r.table_overflow = overflow_flag;
        return r;
    endfunction

    // predicts the result of one request and updates the shadow table
    function automatic mewt_rsp_t update_edge_table(logic cmd, logic [63:0] hash,
                                                    logic [15:0] asm_no, logic start,
                                                    logic [11:0] idx);
        logic [63:0] lo;
        logic [63:0] hi;
        int          pos;
        int          limit;
        if (cmd == CMD_READ)
        begin
            if (idx < SLOTS && shadow_valid[idx])
                return make_result(KIND_SLOT, 1'b1, shadow_lo[idx], shadow_hi[idx],
                                   shadow_weight[idx], 1'b0);
            return make_result(KIND_SLOT, 1'b0, '0, '0, '0, 1'b0);
        end
        if (start || !last_hash_seen)
        begin
            last_hash      = hash;
            last_hash_seen = 1'b1;
            return make_result(KIND_EDGE, 1'b0, '0, '0, '0, 1'b0);
        end
        lo        = (last_hash < hash) ? last_hash : hash;
        hi        = (last_hash < hash) ? hash : last_hash;
        last_hash = hash;
        limit     = (PROBES < SLOTS) ? PROBES : SLOTS;
        pos       = edge_home(lo, hi);
        for (int n = 0; n < limit; n++)
        begin
            if (!shadow_valid[pos])
            begin
                shadow_valid[pos]  = 1'b1;
                shadow_lo[pos]     = lo;
                shadow_hi[pos]     = hi;
                shadow_weight[pos] = 17'd1;
                shadow_asm[pos]    = asm_no;
                used_slots.insert(used_slots.size(), pos);
                return make_result(KIND_EDGE, 1'b1, lo, hi, 17'd1, 1'b1);
            end
            if (shadow_lo[pos] == lo && shadow_hi[pos] == hi)
            begin
                if (shadow_asm[pos] != asm_no)
                begin
                    if (shadow_weight[pos] < WEIGHT_MAX)
                        shadow_weight[pos] = shadow_weight[pos] + 17'd1;
                    shadow_asm[pos] = asm_no;
                end
                return make_result(KIND_EDGE, 1'b1, lo, hi, shadow_weight[pos], 1'b0);
            end
            pos = (pos + 1) % SLOTS;
        end
        overflow_flag = 1'b1;
        return make_result(KIND_EDGE, 1'b1, lo, hi, '0, 1'b0);
    endfunction

    // sends one request, with an optional idle burst before it
    task automatic send_request(logic cmd, logic [63:0] hash, logic [15:0] asm_no,
                                logic start, logic [11:0] idx);
        int gap;
        if (!quiet && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 12);
            repeat (gap)
            begin
                @(negedge clk);
                req_if.valid <= 1'b0;
            end
        end
        @(negedge clk);
        req_if.valid           <= 1'b1;
        req_if.command         <= cmd;
        req_if.minimizer_hash  <= hash;
        req_if.assembly_number <= asm_no;
        req_if.record_start    <= start;
        req_if.slot_index      <= idx;
        do
            @(posedge clk);
        while (!req_if.ready);
        pending_results.insert(pending_results.size(),
                               update_edge_table(cmd, hash, asm_no, start, idx));
    endtask

    task automatic send_hash(logic [63:0] hash, logic [15:0] asm_no, logic start);
        send_request(CMD_HASH, hash, asm_no, start, 12'($urandom));
    endtask

    task automatic send_read(logic [11:0] idx);
        send_request(CMD_READ, {$urandom, $urandom}, 16'($urandom), 1'($urandom), idx);
    endtask

    task automatic stop_sending();
        @(negedge clk);
        req_if.valid <= 1'b0;
    endtask

    task automatic wait_for_results();
        stop_sending();
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [11:0] pick_slot();
        if (used_slots.size() != 0 && $urandom_range(0, 2) != 0)
            return 12'(used_slots[$urandom_range(0, used_slots.size() - 1)]);
        return 12'($urandom);
    endfunction

    // record starts, edge updates, endpoint order, extremes and slot readout
    task automatic test_directed();
        send_hash(64'h0000_0000_0000_0005, 16'd0, 1'b0);
        send_hash(64'h0000_0000_0000_0003, 16'd0, 1'b0);
        send_hash(64'h0000_0000_0000_0005, 16'd0, 1'b0);
        send_hash(64'h0000_0000_0000_0003, 16'd1, 1'b0);
        send_hash(64'h0000_0000_0000_0003, 16'd1, 1'b0);
        send_hash(64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 1'b1);
        send_hash(64'h0000_0000_0000_0000, 16'hFFFF, 1'b0);
        send_hash(64'hFFFF_FFFF_FFFF_FFFF, 16'h0000, 1'b0);
        send_hash(64'hFFFF_FFFF_FFFF_FFFF, 16'h0000, 1'b0);
        send_hash(64'h0000_0000_0000_0000, 16'hFFFF, 1'b0);
        send_hash(64'hA5A5_5A5A_0F0F_F0F0, 16'h1234, 1'b1);
        send_read(12'd0);
        send_read(12'd4095);
        send_hash(64'h5A5A_A5A5_F0F0_0F0F, 16'h4321, 1'b0);
        foreach (used_slots[i])
            send_read(12'(used_slots[i]));
        send_hash(64'h0000_0000_0000_0003, 16'd2, 1'b1);
        send_hash(64'h0000_0000_0000_0005, 16'd3, 1'b0);
        wait_for_results();
    endtask

    // records over a small hash pool so edges repeat across assemblies
    task automatic test_random_records(int count);
        logic [63:0] pool [16];
        int          sent;
        int          rec_len;
        logic [15:0] asm_no;
        foreach (pool[i])
            pool[i] = {$urandom, $urandom};
        sent = 0;
        while (sent < count)
        begin
            rec_len = $urandom_range(1, 10);
            asm_no  = 16'($urandom_range(0, 5));
            if ($urandom_range(0, 9) == 0)
                asm_no = 16'($urandom);
            for (int k = 0; k < rec_len && sent < count; k++)
            begin
                case ($urandom_range(0, 9))
                    0: send_read(pick_slot());
                    1: send_hash({$urandom, $urandom}, asm_no, 1'($urandom));
                    2: send_hash(pool[$urandom_range(0, 15)], 16'($urandom), 1'b0);
                    default: send_hash(pool[$urandom_range(0, 15)], asm_no, k == 0);
                endcase
                sent++;
            end
        end
    endtask

    // receiver holds off while requests keep coming, then the sender drains
    task automatic test_backpressure();
        hold_request = 300;
        test_random_records(40);
        wait_for_results();
        test_random_records(30);
        wait_for_results();
    endtask

    // response ready with random stall bursts and long hold-offs
    int hold_left;
    int stall_left;
    always @(negedge clk)
    begin
        if (hold_request > 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            rsp_if.ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            rsp_if.ready <= 1'b0;
        end
        else if (!quiet && $urandom_range(0, 9) == 0)
        begin
            stall_left = $urandom_range(0, 11);
            rsp_if.ready <= 1'b0;
        end
        else
            rsp_if.ready <= 1'b1;
    end

    // result checking
    always @(posedge clk)
    begin
        mewt_rsp_t got;
        mewt_rsp_t want;
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            got.result_kind    = rsp_if.result_kind;
            got.edge_present   = rsp_if.edge_present;
            got.smaller_hash   = rsp_if.smaller_hash;
            got.larger_hash    = rsp_if.larger_hash;
            got.edge_weight    = rsp_if.edge_weight;
            got.newly_inserted = rsp_if.newly_inserted;
            got.table_overflow = rsp_if.table_overflow;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result kind=%0d present=%0d lo=%h hi=%h w=%0d",
                             got.result_kind, got.edge_present, got.smaller_hash,
                             got.larger_hash, got.edge_weight);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.result_kind !== want.result_kind
                    || got.edge_present !== want.edge_present
                    || got.smaller_hash !== want.smaller_hash
                    || got.larger_hash !== want.larger_hash
                    || got.edge_weight !== want.edge_weight
                    || got.newly_inserted !== want.newly_inserted
                    || got.table_overflow !== want.table_overflow)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("exp kind=%0d pres=%0d lo=%h hi=%h w=%0d new=%0d ovf=%0d",
                                 want.result_kind, want.edge_present, want.smaller_hash,
                                 want.larger_hash, want.edge_weight, want.newly_inserted,
                                 want.table_overflow);
                        $display("act kind=%0d pres=%0d lo=%h hi=%h w=%0d new=%0d ovf=%0d",
                                 got.result_kind, got.edge_present, got.smaller_hash,
                                 got.larger_hash, got.edge_weight, got.newly_inserted,
                                 got.table_overflow);
                    end
                end
            end
        end
    end

    // watchdog on cycles with no handshake
    always @(posedge clk)
    begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        rst_n                  = 1'b0;
        req_if.valid           = 1'b0;
        req_if.command         = CMD_HASH;
        req_if.minimizer_hash  = '0;
        req_if.assembly_number = '0;
        req_if.record_start    = 1'b0;
        req_if.slot_index      = '0;
        rsp_if.ready           = 1'b0;
        mismatches             = 0;
        quiet                  = 1'b0;
        hold_request           = 0;
        hold_left              = 0;
        stall_left             = 0;
        idle_cycles            = 0;
        last_hash              = '0;
        last_hash_seen         = 1'b0;
        overflow_flag          = 1'b0;
        foreach (shadow_valid[i])
            shadow_valid[i] = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_random_records(1300);
        test_backpressure();
        quiet = 1'b1;
        test_random_records(150);
        wait_for_results();
        repeat (200) @(posedge clk);

        if (mismatches == 0 && pending_results.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
`default_nettype wire
